// ===== rtl/bfba_pkg.sv =====
package bfba_pkg;

	localparam int BFBA_MAX_BLOCKS = 16;
	localparam int ADDR_W          = 16;
	localparam int STATUS_W        = 3;
	localparam int INDEX_W         = 4;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd4;

	// Write strobes broadcast from the controller to every cell.
	typedef struct packed {
		logic ins;
		logic upd;
	} wr_t;

endpackage

// ===== rtl/bfba_cell.sv =====
module bfba_cell #(
	parameter int MAX_BLOCKS = 16,
	parameter int CELL_IDX   = 0,
	parameter int IW         = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                         clk,
	input  logic [IW-1:0]                count,
	input  logic [bfba_pkg::ADDR_W-1:0]  new_start,
	input  logic [bfba_pkg::ADDR_W-1:0]  new_size,
	input  logic [bfba_pkg::ADDR_W:0]    new_end,
	input  logic [bfba_pkg::ADDR_W-1:0]  prev_start,
	input  logic [bfba_pkg::ADDR_W-1:0]  prev_orig,
	input  logic [bfba_pkg::ADDR_W-1:0]  prev_free,
	output logic [bfba_pkg::ADDR_W-1:0]  own_start,
	output logic [bfba_pkg::ADDR_W-1:0]  own_orig,
	output logic [bfba_pkg::ADDR_W-1:0]  own_free,
	input  logic                         ovl_in,
	input  logic [IW-1:0]                pos_in,
	input  logic                         found_in,
	input  logic [bfba_pkg::ADDR_W-1:0]  gap_in,
	input  logic [IW-1:0]                idx_in,
	input  logic [bfba_pkg::ADDR_W-1:0]  bstart_in,
	output logic                         ovl_out,
	output logic [IW-1:0]                pos_out,
	output logic                         found_out,
	output logic [bfba_pkg::ADDR_W-1:0]  gap_out,
	output logic [IW-1:0]                idx_out,
	output logic [bfba_pkg::ADDR_W-1:0]  bstart_out,
	input  bfba_pkg::wr_t                wr,
	input  logic [IW-1:0]                wr_pos,
	input  logic [bfba_pkg::ADDR_W-1:0]  wr_gap
);
	import bfba_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic [ADDR_W-1:0] start_q, orig_q, free_q;
	logic              valid;
	logic [ADDR_W:0]   lo, hi;
	logic              hit;
	logic              fit, take;
	logic [ADDR_W-1:0] gap;

	assign own_start = start_q;
	assign own_orig  = orig_q;
	assign own_free  = free_q;

	always_comb begin
		valid = MY_IDX < count;
		lo    = {1'b0, start_q};
		hi    = lo + {1'b0, orig_q};
		hit   = valid && (({1'b0, new_start} > lo && {1'b0, new_start} < hi) ||
			(new_end > lo && new_end < hi));
		fit   = valid && (free_q >= new_size);
		gap   = free_q - new_size;
		take  = fit && (!found_in || gap < gap_in);
	end

	// The scan front moves one cell per cycle; each cell folds its entry in.
	always_ff @(posedge clk) begin
		ovl_out    <= ovl_in | hit;
		pos_out    <= pos_in + IW'(valid && start_q <= new_start);
		found_out  <= found_in | take;
		gap_out    <= take ? gap : gap_in;
		idx_out    <= take ? MY_IDX : idx_in;
		bstart_out <= take ? start_q : bstart_in;
	end

	always_ff @(posedge clk) begin
		if (wr.ins) begin
			if (MY_IDX > wr_pos) begin
				start_q <= prev_start;
				orig_q  <= prev_orig;
				free_q  <= prev_free;
			end else if (MY_IDX == wr_pos) begin
				start_q <= new_start;
				orig_q  <= new_size;
				free_q  <= new_size;
			end
		end else if (wr.upd && MY_IDX == wr_pos) begin
			free_q <= wr_gap;
		end
	end

endmodule

// ===== rtl/best_fit_block_allocator_core.sv =====
// An accepted request is carried by a scan front that walks the chain of entry
// cells one cell per cycle; its result is registered after the last cell. The
// next request is held off until that result commits, which waits on a stall.
// Reset clears the entry count and handshake state; entry contents are left
// as they are and only entries below the count are ever looked at.
module best_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = bfba_pkg::BFBA_MAX_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [bfba_pkg::ADDR_W-1:0]   start_address,
	input  logic [bfba_pkg::ADDR_W-1:0]   size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfba_pkg::STATUS_W-1:0] status,
	output logic [bfba_pkg::INDEX_W-1:0]  block_index,
	output logic [bfba_pkg::ADDR_W-1:0]   block_start,
	output logic [bfba_pkg::ADDR_W-1:0]   remaining
);
	import bfba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS + 1);
	localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS);

	logic              busy_q;
	logic [IW-1:0]     cnt_q;
	logic [IW-1:0]     count_q;
	logic              cmd_q;
	logic [ADDR_W-1:0] start_q, size_q;
	logic [ADDR_W:0]   end_w;
	logic              out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  index_q;
	logic [ADDR_W-1:0]   bstart_q, rem_q;

	logic [ADDR_W-1:0] c_start [MAX_BLOCKS+1];
	logic [ADDR_W-1:0] c_orig  [MAX_BLOCKS+1];
	logic [ADDR_W-1:0] c_free  [MAX_BLOCKS+1];
	logic              s_ovl   [MAX_BLOCKS+1];
	logic [IW-1:0]     s_pos   [MAX_BLOCKS+1];
	logic              s_found [MAX_BLOCKS+1];
	logic [ADDR_W-1:0] s_gap   [MAX_BLOCKS+1];
	logic [IW-1:0]     s_idx   [MAX_BLOCKS+1];
	logic [ADDR_W-1:0] s_bst   [MAX_BLOCKS+1];

	logic              commit;
	wr_t               wr;
	logic [IW-1:0]     wr_pos;
	logic              add_ok;

	assign in_stall    = busy_q;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = index_q;
	assign block_start = bstart_q;
	assign remaining   = rem_q;
	assign end_w       = {1'b0, start_q} + {1'b0, size_q};

	// Head of the chain: neutral scan values and no neighbor for cell zero.
	assign c_start[0] = '0;
	assign c_orig[0]  = '0;
	assign c_free[0]  = '0;
	assign s_ovl[0]   = 1'b0;
	assign s_pos[0]   = '0;
	assign s_found[0] = 1'b0;
	assign s_gap[0]   = '0;
	assign s_idx[0]   = '0;
	assign s_bst[0]   = '0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		bfba_cell #(
			.MAX_BLOCKS(MAX_BLOCKS),
			.CELL_IDX  (g),
			.IW        (IW)
		) u_cell (
			.clk       (clk),
			.count     (count_q),
			.new_start (start_q),
			.new_size  (size_q),
			.new_end   (end_w),
			.prev_start(c_start[g]),
			.prev_orig (c_orig[g]),
			.prev_free (c_free[g]),
			.own_start (c_start[g+1]),
			.own_orig  (c_orig[g+1]),
			.own_free  (c_free[g+1]),
			.ovl_in    (s_ovl[g]),
			.pos_in    (s_pos[g]),
			.found_in  (s_found[g]),
			.gap_in    (s_gap[g]),
			.idx_in    (s_idx[g]),
			.bstart_in (s_bst[g]),
			.ovl_out   (s_ovl[g+1]),
			.pos_out   (s_pos[g+1]),
			.found_out (s_found[g+1]),
			.gap_out   (s_gap[g+1]),
			.idx_out   (s_idx[g+1]),
			.bstart_out(s_bst[g+1]),
			.wr        (wr),
			.wr_pos    (wr_pos),
			.wr_gap    (s_gap[MAX_BLOCKS])
		);
	end

	// The tail of the chain holds the full answer once every cell has been passed.
	always_comb begin
		commit = busy_q && cnt_q == LAST && (!out_valid_q || !out_stall);
		add_ok = !s_ovl[MAX_BLOCKS] && count_q < LAST;
		wr.ins = commit && cmd_q == CMD_ADD && add_ok;
		wr.upd = commit && cmd_q == CMD_ALLOC && s_found[MAX_BLOCKS];
		wr_pos = (cmd_q == CMD_ADD) ? s_pos[MAX_BLOCKS] : s_idx[MAX_BLOCKS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q && in_valid) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q && cnt_q != LAST) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (commit) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				if (wr.ins)
					count_q <= count_q + IW'(1);
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			cmd_q   <= command;
			start_q <= start_address;
			size_q  <= size;
		end
		if (commit) begin
			case (cmd_q)
				CMD_ADD: begin
					if (s_ovl[MAX_BLOCKS]) begin
						status_q <= ST_OVERLAP;
						index_q  <= '0;
						bstart_q <= '0;
						rem_q    <= '0;
					end else if (!add_ok) begin
						status_q <= ST_FULL;
						index_q  <= '0;
						bstart_q <= '0;
						rem_q    <= '0;
					end else begin
						status_q <= ST_ADDED;
						index_q  <= INDEX_W'(s_pos[MAX_BLOCKS]);
						bstart_q <= start_q;
						rem_q    <= size_q;
					end
				end
				CMD_ALLOC: begin
					if (s_found[MAX_BLOCKS]) begin
						status_q <= ST_ALLOC;
						index_q  <= INDEX_W'(s_idx[MAX_BLOCKS]);
						bstart_q <= s_bst[MAX_BLOCKS];
						rem_q    <= s_gap[MAX_BLOCKS];
					end else begin
						status_q <= ST_NOFIT;
						index_q  <= '0;
						bstart_q <= '0;
						rem_q    <= '0;
					end
				end
				default: begin
					status_q <= ST_NOFIT;
					index_q  <= '0;
					bstart_q <= '0;
					rem_q    <= '0;
				end
			endcase
		end
	end

endmodule
